/* hdl/sha1bsh_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types, constants and round functions for the controller and the
// datapath of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

   localparam logic CMD_APPEND   = 1'b0;
   localparam logic CMD_FINALIZE = 1'b1;

   localparam logic [0:4][31:0] H_INIT = {
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] K_ROUND0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [6:0] ROUND_LAST     = 7'd79;
   localparam logic [6:0] ROUND_SCHED    = 7'd16;
   localparam logic [6:0] ROUND_PHASE1   = 7'd20;
   localparam logic [6:0] ROUND_PHASE2   = 7'd40;
   localparam logic [6:0] ROUND_PHASE3   = 7'd60;
   localparam logic [5:0] FILL_LAST      = 6'd63;
   localparam logic [5:0] FILL_LEN_START = 6'd56;
   localparam logic [2:0] WORD_LAST      = 3'd4;

   typedef enum logic [1:0] {
      BYTE_DATA,
      BYTE_PAD,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic         load_byte;
      byte_sel_type byte_sel;
      logic         count_len;
      logic         start_round;
      logic         do_round;
      logic         update_chain;
      logic         emit_next;
      logic         reinit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
      logic       emit_last;
   } dp_status_type;

   function automatic logic [31:0] round_func(input logic [6:0] round,
                                              input logic [31:0] b,
                                              input logic [31:0] c,
                                              input logic [31:0] d);
      logic [31:0] res;
      if (round < ROUND_PHASE1) begin
         res = (b & c) | (~b & d);
      end else if (round < ROUND_PHASE2) begin
         res = b ^ c ^ d;
      end else if (round < ROUND_PHASE3) begin
         res = (b & c) | (b & d) | (c & d);
      end else begin
         res = b ^ c ^ d;
      end
      return res;
   endfunction

   function automatic logic [31:0] round_const(input logic [6:0] round);
      logic [31:0] res;
      if (round < ROUND_PHASE1) begin
         res = K_ROUND0;
      end else if (round < ROUND_PHASE2) begin
         res = K_ROUND1;
      end else if (round < ROUND_PHASE3) begin
         res = K_ROUND2;
      end else begin
         res = K_ROUND3;
      end
      return res;
   endfunction

endpackage

/* hdl/sha1bsh_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-1 hasher datapath
// Byte packing into a 16-word rolling schedule, length counter, one SHA-1
// round per cycle, chaining update and digest word selection.
// ----------------------------------------------------------------------------
module sha1bsh_datapath
   import sha1bsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   input  logic [7:0]    data_byte,
   output dp_status_type status,
   output logic [31:0]   digest_word,
   output logic [2:0]    word_index,
   output logic          too_long
);

   logic [0:4][31:0] h_ff, h_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic [15:0][31:0] w_ff, w_in;
   logic [23:0]      acc_ff, acc_in;
   logic [5:0]       fill_ff, fill_in;
   logic [63:0]      len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [6:0]       round_ff, round_in;
   logic [2:0]       idx_ff, idx_in;

   logic [7:0]       byte_val;
   logic [2:0]       len_sel;
   logic [31:0]      sched_x;
   logic [31:0]      wr;
   logic [31:0]      temp;
   logic [64:0]      len_sum;

   // Length bytes go out most significant first at block offsets 56 to 63.
   assign len_sel = ~fill_ff[2:0];

   always_comb begin
      case (cmd.byte_sel)
         BYTE_DATA: byte_val = data_byte;
         BYTE_PAD:  byte_val = PAD_BYTE;
         BYTE_ZERO: byte_val = 8'h00;
         BYTE_LEN:  byte_val = len_ff[{len_sel, 3'b000} +: 8];
         default:   byte_val = 8'h00;
      endcase
   end

   // Slot j of the schedule holds W[r+j-16] once the first 16 rounds are done.
   assign sched_x = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign wr      = (round_ff < ROUND_SCHED) ? w_ff[0] : {sched_x[30:0], sched_x[31]};
   assign temp    = {a_ff[26:0], a_ff[31:27]} + round_func(round_ff, b_ff, c_ff, d_ff)
                    + e_ff + wr + round_const(round_ff);
   assign len_sum = {1'b0, len_ff} + 65'd8;

   always_comb begin
      h_in     = h_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      w_in     = w_ff;
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      round_in = round_ff;
      idx_in   = idx_ff;

      if (cmd.load_byte) begin
         acc_in  = {acc_ff[15:0], byte_val};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            w_in = {{acc_ff, byte_val}, w_ff[15:1]};
         end
      end
      if (cmd.count_len) begin
         len_in = len_sum[63:0];
         if (len_sum[64]) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.start_round) begin
         a_in     = h_ff[0];
         b_in     = h_ff[1];
         c_in     = h_ff[2];
         d_in     = h_ff[3];
         e_in     = h_ff[4];
         round_in = 7'd0;
      end
      if (cmd.do_round) begin
         a_in     = temp;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         w_in     = {wr, w_ff[15:1]};
         round_in = round_ff + 7'd1;
      end
      if (cmd.update_chain) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
         idx_in  = 3'd0;
      end
      if (cmd.emit_next) begin
         idx_in = idx_ff + 3'd1;
      end
      if (cmd.reinit) begin
         h_in    = H_INIT;
         fill_in = 6'd0;
         len_in  = 64'd0;
         ovf_in  = 1'b0;
         idx_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff     <= H_INIT;
         fill_ff  <= 6'd0;
         len_ff   <= 64'd0;
         ovf_ff   <= 1'b0;
         round_ff <= 7'd0;
         idx_ff   <= 3'd0;
      end else begin
         h_ff     <= h_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
      w_ff   <= w_in;
      acc_ff <= acc_in;
   end

   always_comb begin
      case (idx_ff)
         3'd0:    digest_word = h_ff[0];
         3'd1:    digest_word = h_ff[1];
         3'd2:    digest_word = h_ff[2];
         3'd3:    digest_word = h_ff[3];
         3'd4:    digest_word = h_ff[4];
         default: digest_word = h_ff[4];
      endcase
   end

   assign word_index        = idx_ff;
   assign too_long          = ovf_ff;
   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == ROUND_LAST);
   assign status.emit_last  = (idx_ff == WORD_LAST);

endmodule

/* hdl/sha1bsh_controller.sv */
// ----------------------------------------------------------------------------
// SHA-1 hasher controller
// Sequences byte loading, padding, the 80 compression rounds, the chaining
// update and the five digest transactions.
// ----------------------------------------------------------------------------
module sha1bsh_controller
   import sha1bsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      pad80_ff, pad80_in;
   logic      len_ok_ff, len_ok_in;
   logic      block_full;

   assign block_full = (status.fill == FILL_LAST);

   // Next state and padding flags.
   always_comb begin
      state_in  = state_ff;
      fin_in    = fin_ff;
      pad80_in  = pad80_ff;
      len_ok_in = len_ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_FINALIZE) begin
                  fin_in    = 1'b1;
                  pad80_in  = 1'b1;
                  len_ok_in = 1'b0;
                  state_in  = ST_PAD;
               end else if (block_full) begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            if (pad80_ff) begin
               pad80_in  = 1'b0;
               // The length fits in this block only if the pad byte lands early enough.
               len_ok_in = (status.fill < FILL_LEN_START);
            end
            if (block_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (status.round_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_ok_ff) begin
               state_in = ST_EMIT;
            end else begin
               // An extra block was needed; the next one carries the length.
               len_ok_in = 1'b1;
               state_in  = ST_PAD;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.emit_last) begin
               fin_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands and handshake outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.byte_sel  = BYTE_DATA;
            if (req_valid && (req_command == CMD_APPEND)) begin
               cmd.load_byte   = 1'b1;
               cmd.count_len   = 1'b1;
               cmd.start_round = block_full;
            end
         end
         ST_PAD: begin
            cmd.load_byte   = 1'b1;
            cmd.start_round = block_full;
            if (pad80_ff) begin
               cmd.byte_sel = BYTE_PAD;
            end else if (len_ok_ff && (status.fill >= FILL_LEN_START)) begin
               cmd.byte_sel = BYTE_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
            end
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update_chain = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = rsp_ready;
            cmd.reinit    = rsp_ready && status.emit_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fin_ff    <= 1'b0;
         pad80_ff  <= 1'b0;
         len_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fin_ff    <= fin_in;
         pad80_ff  <= pad80_in;
         len_ok_ff <= len_ok_in;
      end
   end

endmodule

/* hdl/sha1_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a message fed one byte per transaction and returns the 160-bit
// digest as five 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
// A req_ transaction with req_command low appends req_data_byte to the
// message; with req_command high it finalizes the message. Appends are
// taken back to back, except that after the byte that completes a 64-byte
// block req_ready stays low while the single shared round unit runs the
// compression rounds and then the chaining update.
// Finalize pads the message one byte per cycle through the same byte path
// (pad byte, zero fill and the 64-bit length), then compresses the block,
// and pads and compresses another block when the length does not fit in
// the current block. The five digest words then leave on the rsp_
// channel, word 0 first, rsp_last_word marking word 4 and rsp_too_long
// flagging a wrapped length counter. A stalled rsp_ready holds the current
// word; no request is taken until word 4 is accepted, after which the block
// is ready for the next message. Reset leaves it idle, ready for a new
// message with the initial chaining values.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher
   import sha1bsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_too_long
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sha1bsh_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   sha1bsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word),
      .word_index  (rsp_word_index),
      .too_long    (rsp_too_long)
   );

   assign rsp_last_word = status.emit_last;

endmodule

/* hdl/sha1bsh_checker.sv */
// ----------------------------------------------------------------------------
// SHA-1 hasher port checker
// Checks digest transaction ordering and the handshake as seen at the ports.
// ----------------------------------------------------------------------------
module sha1bsh_checker
   import sha1bsh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_command,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word,
   input logic        rsp_too_long
);

   // A stalled digest transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_index) && $stable(rsp_too_long))
      else $error("digest payload changed while stalled");

   // No request is taken while the digest is being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted during digest output");

   // The last marker belongs to word four and to no other.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == WORD_LAST)))
      else $error("last word marker does not match word index");

   // After the last word the block goes idle, and an append produces no digest.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word)
         || (req_valid && req_ready && (req_command == CMD_APPEND))
      |=> !rsp_valid)
      else $error("digest output without a finalize");

endmodule

bind sha1_byte_stream_hasher sha1bsh_checker u_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Feeds messages byte by byte, finalizes them and checks every digest word
// against a software SHA-1 kept in step with the accepted requests. Both
// sides throttle at random, and one long response stall backs up the input.
// ----------------------------------------------------------------------------
module tb
   import sha1bsh_pkg::*;
();

   typedef struct {
      logic       command;
      logic [7:0] data_byte;
   } hash_request_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
      logic        too_long;
   } digest_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_APPEND;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_too_long;

   hash_request_type  pending_requests[$];
   digest_result_type expected_digest_words[$];

   // Software SHA-1 state, advanced on every accepted request.
   logic [31:0] chain_words[5];
   logic [7:0]  block_buffer[64];
   int          block_fill;
   logic [63:0] message_bits;
   logic        length_wrapped;

   int total_requests = 0;
   int issued_requests = 0;
   int bytes_hashed = 0;
   int messages_hashed = 0;
   int words_checked = 0;
   int error_count = 0;
   int stall_cycles_left = 0;
   bit long_stall_done = 1'b0;

   sha1_byte_stream_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .rsp_too_long    (rsp_too_long)
   );

   always #10 clock = ~clock;

   function automatic void restart_hash();
      for (int i = 0; i < 5; i++) begin
         chain_words[i] = H_INIT[i];
      end
      for (int i = 0; i < 64; i++) begin
         block_buffer[i] = 8'h00;
      end
      block_fill = 0;
      message_bits = '0;
      length_wrapped = 1'b0;
   endfunction

   function automatic void compress_buffer();
      logic [31:0] sched[16];
      logic [31:0] a, b, c, d, e, f, k, t, wr, x;
      for (int i = 0; i < 16; i++) begin
         sched[i] = {block_buffer[4*i], block_buffer[4*i+1],
                     block_buffer[4*i+2], block_buffer[4*i+3]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = sched[r];
         end else begin
            x = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15] ^
                sched[r & 15];
            wr = {x[30:0], x[31]};
            sched[r & 15] = wr;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = {a[26:0], a[31:27]} + f + e + wr + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
   endfunction

   function automatic void absorb_request(input logic command, input logic [7:0] data_byte);
      int pos;
      digest_result_type word;
      if (command == CMD_APPEND) begin
         block_buffer[block_fill] = data_byte;
         message_bits += 64'd8;
         if (message_bits == '0) begin
            length_wrapped = 1'b1;
         end
         block_fill++;
         if (block_fill == 64) begin
            compress_buffer();
            block_fill = 0;
         end
      end else begin
         pos = block_fill;
         block_buffer[pos] = PAD_BYTE;
         pos++;
         // The length needs the last 8 bytes, so a late pad spills into a new block.
         if (pos > 56) begin
            while (pos < 64) begin
               block_buffer[pos] = 8'h00;
               pos++;
            end
            compress_buffer();
            pos = 0;
         end
         while (pos < 56) begin
            block_buffer[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            block_buffer[56 + i] = message_bits[63 - 8*i -: 8];
         end
         compress_buffer();
         for (int i = 0; i < 5; i++) begin
            word.digest_word = chain_words[i];
            word.word_index = 3'(i);
            word.last_word = (i == 4);
            word.too_long = length_wrapped;
            expected_digest_words.push_back(word);
         end
         restart_hash();
      end
   endfunction

   function automatic int idle_phase();
      int p;
      p = (total_requests == 0) ? 2 : issued_requests * 3 / total_requests;
      return (p > 2) ? 2 : p;
   endfunction

   task automatic queue_message(input int length);
      hash_request_type req;
      for (int i = 0; i < length; i++) begin
         req.command = CMD_APPEND;
         req.data_byte = 8'($urandom_range(255));
         pending_requests.push_back(req);
      end
      req.command = CMD_FINALIZE;
      req.data_byte = 8'($urandom_range(255));
      pending_requests.push_back(req);
   endtask

   // Request driver.
   always @(posedge clock) begin
      int sender_idle_pct;
      hash_request_type req;
      sender_idle_pct = (idle_phase() == 0) ? 18 : (idle_phase() == 1) ? 63 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req = pending_requests.pop_front();
            issued_requests++;
            req_valid <= 1'b1;
            req_command <= req.command;
            req_data_byte <= req.data_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response acceptor, with one long stall while a digest is being returned.
   always @(posedge clock) begin
      int recv_idle_pct;
      recv_idle_pct = (idle_phase() == 0) ? 63 : (idle_phase() == 1) ? 18 : 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_cycles_left != 0) begin
         stall_cycles_left <= stall_cycles_left - 1;
         rsp_ready <= 1'b0;
      end else if (!long_stall_done && idle_phase() == 2 && rsp_valid) begin
         stall_cycles_left <= 300;
         long_stall_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: check returned digest words, then advance the model.
   always @(posedge clock) begin
      digest_result_type exp_word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_digest_words.size() == 0) begin
               $error("unexpected digest word %h at index %0d", rsp_digest_word,
                      rsp_word_index);
               error_count++;
            end else begin
               exp_word = expected_digest_words.pop_front();
               if (rsp_digest_word !== exp_word.digest_word) begin
                  $error("digest_word mismatch: expected %h, got %h",
                         exp_word.digest_word, rsp_digest_word);
                  error_count++;
               end
               if (rsp_word_index !== exp_word.word_index) begin
                  $error("word_index mismatch: expected %0d, got %0d",
                         exp_word.word_index, rsp_word_index);
                  error_count++;
               end
               if (rsp_last_word !== exp_word.last_word) begin
                  $error("last_word mismatch: expected %0b, got %0b",
                         exp_word.last_word, rsp_last_word);
                  error_count++;
               end
               if (rsp_too_long !== exp_word.too_long) begin
                  $error("too_long mismatch: expected %0b, got %0b",
                         exp_word.too_long, rsp_too_long);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_APPEND) begin
               bytes_hashed++;
            end else begin
               messages_hashed++;
            end
            absorb_request(req_command, req_data_byte);
         end
      end
   end

   initial begin
      int random_requests;
      int msg_count;
      int long_lengths[3];
      int length;
      long_lengths = '{55, 56, 64};
      restart_hash();

      // Empty message, then a short one with all-zero and all-one bytes.
      queue_message(0);
      pending_requests[$].data_byte = 8'hff;
      pending_requests.push_back('{CMD_APPEND, 8'h00});
      pending_requests.push_back('{CMD_APPEND, 8'hff});
      pending_requests.push_back('{CMD_APPEND, 8'h61});
      pending_requests.push_back('{CMD_FINALIZE, 8'h00});

      // Random messages: mostly short, with the padding boundaries mixed in.
      random_requests = 0;
      msg_count = 0;
      while (random_requests < 160 || msg_count < 8) begin
         if (msg_count % 2 == 1 && msg_count / 2 < 3) begin
            length = long_lengths[msg_count / 2];
         end else begin
            length = $urandom_range(0, 20);
         end
         queue_message(length);
         random_requests += length + 1;
         msg_count++;
      end
      total_requests = pending_requests.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_digest_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (50) @(posedge clock);

      $display("Hashed %0d messages from %0d bytes, including empty and block-boundary",
               messages_hashed, bytes_hashed);
      $display("lengths; %0d digest words checked, %0d mismatches.",
               words_checked, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d digest words outstanding.", expected_digest_words.size());
      $display("Verification failed");
      $finish;
   end

endmodule
